>>> hdl/ipv4_l4_checksum_engine_defines.svh
// Assertion macros used by the checker file of the checksum engine.
`ifndef IPV4_L4_CHECKSUM_ENGINE_DEFINES_SVH
`define IPV4_L4_CHECKSUM_ENGINE_DEFINES_SVH

// Checked on every rising edge of clock while reset is low.
`define L4CSUM_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge of clock, reset included.
`define L4CSUM_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/l4csum_pkg.sv
package l4csum_pkg;

   localparam logic [15:0] HDR_BYTES = 16'd20;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [15:0] byte_pos;
      logic [19:0] hdr_sum;
      logic [31:0] pay_sum;
      logic [15:0] tot_len;
      logic [7:0]  proto;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
   } l4csum_pkt_type;

   typedef struct packed {
      logic           valid;
      l4csum_pkt_type pkt;
   } l4csum_push_type;

   typedef struct packed {
      logic           valid;
      l4csum_pkt_type pkt;
   } l4csum_head_type;

   typedef struct packed {
      logic        length_error;
      logic [15:0] l4_checksum;
      logic [15:0] pseudo_header_sum;
      logic [15:0] ip_header_checksum;
   } l4csum_result_type;

endpackage

>>> hdl/l4csum_front.sv
module l4csum_front
   import l4csum_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [15:0]     req_tdata,
   input  logic [1:0]      req_tuser,
   input  logic            req_tlast,
   input  logic            queue_full,
   output l4csum_push_type push
);

   l4csum_pkt_type state_ff, state_in;
   l4csum_pkt_type after_hi, after_lo;
   logic           accept;

   function automatic l4csum_pkt_type take_byte(input l4csum_pkt_type s, input logic [7:0] b);
      l4csum_pkt_type r;
      logic [15:0]    v;
      r = s;
      v = s.byte_pos[0] ? {8'h00, b} : {b, 8'h00};
      if (s.byte_pos < HDR_BYTES) begin
         r.hdr_sum = s.hdr_sum + {4'h0, v};
         if (s.byte_pos == 16'd2 || s.byte_pos == 16'd3) begin
            r.tot_len = {s.tot_len[7:0], b};
         end else if (s.byte_pos == 16'd9) begin
            r.proto = b;
         end else if (s.byte_pos >= 16'd12 && s.byte_pos < 16'd16) begin
            r.src_ip = {s.src_ip[23:0], b};
         end else if (s.byte_pos >= 16'd16) begin
            r.dst_ip = {s.dst_ip[23:0], b};
         end
      end else if (s.byte_pos < s.tot_len) begin
         r.pay_sum = s.pay_sum + {16'h0000, v};
      end
      if (s.byte_pos != 16'hffff) begin
         r.byte_pos = s.byte_pos + 16'd1;
      end
      return r;
   endfunction

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      after_hi = state_ff;
      if (req_tuser != 2'd0) begin
         after_hi = take_byte(state_ff, req_tdata[15:8]);
      end
      after_lo = after_hi;
      if (req_tuser >= 2'd2) begin
         after_lo = take_byte(after_hi, req_tdata[7:0]);
      end
   end

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = req_tlast ? '0 : after_lo;
      end
   end

   always_comb begin
      push.valid = accept && req_tlast;
      push.pkt   = after_lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/l4csum_queue.sv
module l4csum_queue
   import l4csum_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic            clock,
   input  logic            reset,
   input  l4csum_push_type push,
   output logic            full,
   output l4csum_head_type head,
   input  logic            pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   l4csum_pkt_type    slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.pkt   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push.valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/l4csum_back.sv
module l4csum_back
   import l4csum_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              tso_zero_length,
   input  l4csum_head_type   head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output l4csum_result_type result
);

   typedef struct packed {
      logic [16:0] hdr_part;
      logic [16:0] pay_part;
      logic [18:0] addr_sum;
      logic [15:0] l4_len;
      logic        err;
   } s1_type;

   typedef struct packed {
      logic [15:0] hdr_fold;
      logic [15:0] pay_fold;
      logic [18:0] ps_len_raw;
      logic [18:0] ps_zero_raw;
      logic        err;
   } s2_type;

   typedef struct packed {
      logic [15:0] hdr_chk;
      logic [15:0] pay_fold;
      logic [15:0] ps_len;
      logic [15:0] ps_zero;
      logic        err;
   } s3_type;

   s1_type            s1_ff, s1_in;
   s2_type            s2_ff, s2_in;
   s3_type            s3_ff, s3_in;
   l4csum_result_type out_ff, out_in;
   logic              s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in;
   logic              out_v_ff, out_v_in;
   logic              rdy1, rdy2, rdy3, rdy4;
   logic [16:0]       l4_raw;
   logic [15:0]       l4_fold;

   function automatic logic [15:0] fold19(input logic [18:0] s);
      logic [16:0] t;
      t = {14'h0, s[18:16]} + {1'b0, s[15:0]};
      return t[15:0] + {15'h0, t[16]};
   endfunction

   assign rdy4 = !out_v_ff || rsp_tready;
   assign rdy3 = !s3_v_ff || rdy4;
   assign rdy2 = !s2_v_ff || rdy3;
   assign rdy1 = !s1_v_ff || rdy2;
   assign pop  = head.valid && rdy1;

   always_comb begin
      s1_in.hdr_part = {13'h0, head.pkt.hdr_sum[19:16]} + {1'b0, head.pkt.hdr_sum[15:0]};
      s1_in.pay_part = {1'b0, head.pkt.pay_sum[31:16]} + {1'b0, head.pkt.pay_sum[15:0]};
      s1_in.addr_sum = {3'h0, head.pkt.src_ip[31:16]} + {3'h0, head.pkt.src_ip[15:0]}
                     + {3'h0, head.pkt.dst_ip[31:16]} + {3'h0, head.pkt.dst_ip[15:0]}
                     + {11'h0, head.pkt.proto};
      s1_in.l4_len   = (head.pkt.tot_len >= HDR_BYTES) ? head.pkt.tot_len - HDR_BYTES : '0;
      s1_in.err      = (head.pkt.tot_len < HDR_BYTES) || (head.pkt.byte_pos < head.pkt.tot_len);
   end

   always_comb begin
      s2_in.hdr_fold    = s1_ff.hdr_part[15:0] + {15'h0, s1_ff.hdr_part[16]};
      s2_in.pay_fold    = s1_ff.pay_part[15:0] + {15'h0, s1_ff.pay_part[16]};
      s2_in.ps_len_raw  = s1_ff.addr_sum + {3'h0, s1_ff.l4_len};
      s2_in.ps_zero_raw = s1_ff.addr_sum;
      s2_in.err         = s1_ff.err;
   end

   always_comb begin
      s3_in.hdr_chk  = (s2_ff.hdr_fold == 16'hffff) ? 16'hffff : ~s2_ff.hdr_fold;
      s3_in.pay_fold = s2_ff.pay_fold;
      s3_in.ps_len   = fold19(s2_ff.ps_len_raw);
      s3_in.ps_zero  = fold19(s2_ff.ps_zero_raw);
      s3_in.err      = s2_ff.err;
   end

   always_comb begin
      l4_raw  = {1'b0, s3_ff.pay_fold} + {1'b0, s3_ff.ps_len};
      l4_fold = l4_raw[15:0] + {15'h0, l4_raw[16]};
      out_in.ip_header_checksum = s3_ff.hdr_chk;
      out_in.pseudo_header_sum  = tso_zero_length ? s3_ff.ps_zero : s3_ff.ps_len;
      out_in.l4_checksum        = (l4_fold == 16'hffff) ? 16'hffff : ~l4_fold;
      out_in.length_error       = s3_ff.err;
   end

   always_comb begin
      s1_v_in  = rdy1 ? head.valid : s1_v_ff;
      s2_v_in  = rdy2 ? s1_v_ff : s2_v_ff;
      s3_v_in  = rdy3 ? s2_v_ff : s3_v_ff;
      out_v_in = rdy4 ? s3_v_ff : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
      if (rdy2) begin
         s2_ff <= s2_in;
      end
      if (rdy3) begin
         s3_ff <= s3_in;
      end
      if (rdy4) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign result     = out_ff;

endmodule

>>> hdl/ipv4_l4_checksum_engine.sv
// Channel  Direction  Word                                   Sideband
// req      in         tdata: data_word, 16 bits              tuser: byte_count, tlast: last
// rsp      out        tdata: header csum, pseudo sum, L4,    none
//                            length error
// csr      in         csr_wr_data: tso_zero_length           csr_wr_en
//
// One packet word is taken every cycle while the queue is not full; the running sums
// are updated by two chained byte adds in the front.
// A result passes from the queue through a four-stage fold and complement
// pipeline in the back (s1, s2, s3, out).
// Reset is synchronous and clears the packet state, the queue, the pipeline valids and the register.
// Up to QUEUE_DEPTH_P finished packets wait in the queue while rsp is stalled;
// req_tready falls only when that queue is full.
module ipv4_l4_checksum_engine
   import l4csum_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] data_word
   input  logic [1:0]  req_tuser,   // [1:0] byte_count
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] ip_header_checksum, [31:16] pseudo_header_sum,
   // [47:32] l4_checksum, [48] length_error, [55:49] zero
   output logic [55:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic              tso_ff, tso_in;
   l4csum_push_type   push;
   l4csum_head_type   head;
   logic              queue_full;
   logic              pop;
   l4csum_result_type result;

   assign tso_in = csr_wr_en ? csr_wr_data : tso_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tso_ff <= 1'b0;
      end else begin
         tso_ff <= tso_in;
      end
   end

   l4csum_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push)
   );

   l4csum_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   l4csum_back u_back (
      .clock           (clock),
      .reset           (reset),
      .tso_zero_length (tso_ff),
      .head            (head),
      .pop             (pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .result          (result)
   );

   assign rsp_tdata = {7'h00, result.length_error, result.l4_checksum,
                       result.pseudo_header_sum, result.ip_header_checksum};

endmodule

>>> hdl/l4csum_checker.sv
`include "ipv4_l4_checksum_engine_defines.svh"

module l4csum_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // A stalled result word keeps its valid and its payload.
   `L4CSUM_CHECK(rsp_valid_holds, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp_tvalid dropped")
   `L4CSUM_CHECK(rsp_data_holds, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp_tdata changed")

   // Both checksums are complemented folds with zero mapped away, so neither can be zero.
   `L4CSUM_CHECK(csum_nonzero, rsp_tvalid |-> (|rsp_tdata[15:0]) && (|rsp_tdata[47:32]), "zero csum")

   // Reset leaves no result pending.
   `L4CSUM_CHECK_ALWAYS(reset_empties, reset |=> !rsp_tvalid, "result after reset")

endmodule

bind ipv4_l4_checksum_engine l4csum_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
